@@ src/wpst_pkg.sv @@
// ============================================================================
// wpst_pkg
// Shared widths, register indexes and state codes of the windowed power-sum
// threshold detector.
// ============================================================================
`timescale 1ns / 1ps

package wpst_pkg;

  // Lanes carried by one input word.
  localparam int LANES      = 8;
  localparam int ELEM_W     = 16;  // signed Q4.12 lane value
  localparam int FRAC_W     = 12;  // fraction bits dropped after each multiply
  localparam int TERM_W     = 26;  // holds any power 1..4 of a Q4.12 value
  localparam int ROW_W      = 29;  // holds the sum of LANES terms
  localparam int SUM_W      = 56;  // running window sum and threshold
  localparam int IDX_W      = 16;  // window index
  localparam int LEN_CFG_W  = 9;
  localparam int STRIDE_W   = 10;
  localparam int POW_W      = 3;
  localparam int COLS_W     = 4;
  localparam int POW_CNT_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 3'd0,
    CFG_WINDOW_STRIDE = 3'd1,
    CFG_POWER         = 3'd2,
    CFG_THRESHOLD     = 3'd3,
    CFG_COLUMN_COUNT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POW,
    S_SUM,
    S_UPD,
    S_EMIT
  } wpst_state_t;

endpackage

@@ src/wpst_in_if.sv @@
// ============================================================================
// wpst_in_if
// Input channel: one row of lane values and a restart flag per word.
// ============================================================================
`timescale 1ns / 1ps

interface wpst_in_if;
  logic                              valid;
  logic                              ready;
  logic                              restart;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_0;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_1;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_2;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_3;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_4;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_5;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_6;
  logic signed [wpst_pkg::ELEM_W-1:0] elem_7;

  modport source (
    output valid, restart, elem_0, elem_1, elem_2, elem_3,
    output elem_4, elem_5, elem_6, elem_7,
    input  ready
  );

  modport sink (
    input  valid, restart, elem_0, elem_1, elem_2, elem_3,
    input  elem_4, elem_5, elem_6, elem_7,
    output ready
  );
endinterface

@@ src/wpst_out_if.sv @@
// ============================================================================
// wpst_out_if
// Result channel: window sum, threshold flag and window index per word.
// ============================================================================
`timescale 1ns / 1ps

interface wpst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wpst_pkg::SUM_W-1:0] window_sum;
  logic                              anomaly;
  logic [wpst_pkg::IDX_W-1:0]        window_index;

  modport source (
    output valid, window_sum, anomaly, window_index,
    input  ready
  );

  modport sink (
    input  valid, window_sum, anomaly, window_index,
    output ready
  );
endinterface

@@ src/window_power_sum_threshold_core.sv @@
// ============================================================================
// window_power_sum_threshold_core
// Sliding-window detector: raises each lane of a row to a small integer
// power, sums the row, keeps an exact running sum over the last rows and
// flags windows whose sum exceeds a threshold.
// ============================================================================
// Usage: the block takes one input word at a time and works on it through
// its power, sum and update steps before it is ready for the next word; a
// word that closes a window also passes the emit step to hand its result to
// the output register, and stays there while that register is still full.
// The work is done by the power steps through the lane multipliers, by the
// single row adder that folds in one lane per cycle and by the read-modify-write
// of the row-sum ring memory. The output register holds a finished result while
// the next word is already accepted. No clearing pass runs after reset or
// restart: a fill count keeps old ring entries from ever entering the sum, so
// the block is ready right out of reset. Writing window_length or window_stride
// clears the window history just as a restart word does; registers should be
// written only while the block is idle.
`timescale 1ns / 1ps

module window_power_sum_threshold_core #(
  parameter int WIN_MAX = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wpst_in_if.sink                             in_if,
  wpst_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [wpst_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [wpst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int LEN_W  = $clog2(WIN_MAX + 1);
  localparam int CMP_W  = (LEN_W > wpst_pkg::LEN_CFG_W) ? LEN_W : wpst_pkg::LEN_CFG_W;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [wpst_pkg::LEN_CFG_W-1:0]   len_r;
  logic [wpst_pkg::STRIDE_W-1:0]    stride_r;
  logic [wpst_pkg::POW_W-1:0]       pow_r;
  logic signed [wpst_pkg::SUM_W-1:0] thr_r;
  logic [wpst_pkg::COLS_W-1:0]      cols_r;
  logic                             cfg_clear;

  // A new window length or stride invalidates everything gathered so far.
  assign cfg_clear = cfg_we &&
                     ((wpst_pkg::cfg_reg_t'(cfg_idx) == wpst_pkg::CFG_WINDOW_LENGTH) ||
                      (wpst_pkg::cfg_reg_t'(cfg_idx) == wpst_pkg::CFG_WINDOW_STRIDE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= wpst_pkg::LEN_CFG_W'(1);
      stride_r <= wpst_pkg::STRIDE_W'(1);
      pow_r    <= wpst_pkg::POW_W'(2);
      thr_r    <= '0;
      cols_r   <= wpst_pkg::COLS_W'(wpst_pkg::LANES);
    end else if (cfg_we) begin
      unique case (wpst_pkg::cfg_reg_t'(cfg_idx))
        wpst_pkg::CFG_WINDOW_LENGTH: len_r    <= cfg_wdata[wpst_pkg::LEN_CFG_W-1:0];
        wpst_pkg::CFG_WINDOW_STRIDE: stride_r <= cfg_wdata[wpst_pkg::STRIDE_W-1:0];
        wpst_pkg::CFG_POWER:         pow_r    <= cfg_wdata[wpst_pkg::POW_W-1:0];
        wpst_pkg::CFG_THRESHOLD:     thr_r    <= $signed(cfg_wdata[wpst_pkg::SUM_W-1:0]);
        wpst_pkg::CFG_COLUMN_COUNT:  cols_r   <= cfg_wdata[wpst_pkg::COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective settings: out-of-range register values are clamped into range.
  logic [CMP_W-1:0]              len_cfg_ext;
  logic [LEN_W-1:0]              len_eff;
  logic [wpst_pkg::STRIDE_W-1:0] stride_eff;
  logic [wpst_pkg::POW_W-1:0]    pow_eff;
  logic [wpst_pkg::COLS_W-1:0]   cols_eff;

  assign len_cfg_ext = CMP_W'(len_r);

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_cfg_ext > CMP_W'(WIN_MAX)) begin
      len_eff = LEN_W'(WIN_MAX);
    end else begin
      len_eff = LEN_W'(len_cfg_ext);
    end

    stride_eff = (stride_r == '0) ? wpst_pkg::STRIDE_W'(1) : stride_r;

    if (pow_r == '0) begin
      pow_eff = wpst_pkg::POW_W'(1);
    end else if (pow_r > wpst_pkg::POW_W'(4)) begin
      pow_eff = wpst_pkg::POW_W'(4);
    end else begin
      pow_eff = pow_r;
    end

    if (cols_r == '0) begin
      cols_eff = wpst_pkg::COLS_W'(1);
    end else if (cols_r > wpst_pkg::COLS_W'(wpst_pkg::LANES)) begin
      cols_eff = wpst_pkg::COLS_W'(wpst_pkg::LANES);
    end else begin
      cols_eff = cols_r;
    end
  end

  // --------------------------------------------------------------------------
  // Control state machine.
  // --------------------------------------------------------------------------
  wpst_pkg::wpst_state_t state_r;
  wpst_pkg::wpst_state_t state_nxt;

  logic                           in_fire;
  logic                           out_free;
  logic                           last_lane;
  logic                           upd_emit;
  logic                           out_valid_r;
  logic [wpst_pkg::POW_CNT_W-1:0] pow_cnt_r;
  logic [wpst_pkg::COLS_W-1:0]    lane_cnt_r;

  assign in_fire   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_r || out_if.ready;
  assign last_lane = (lane_cnt_r == cols_eff - wpst_pkg::COLS_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    unique case (state_r)
      wpst_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = (pow_eff == wpst_pkg::POW_W'(1)) ? wpst_pkg::S_SUM : wpst_pkg::S_POW;
        end
      end
      wpst_pkg::S_POW: begin
        if (pow_cnt_r == wpst_pkg::POW_CNT_W'(1)) begin
          state_nxt = wpst_pkg::S_SUM;
        end
      end
      wpst_pkg::S_SUM: begin
        if (last_lane) begin
          state_nxt = wpst_pkg::S_UPD;
        end
      end
      wpst_pkg::S_UPD: begin
        state_nxt = upd_emit ? wpst_pkg::S_EMIT : wpst_pkg::S_IDLE;
      end
      wpst_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = wpst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wpst_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Lane datapath. Each lane has its own multiplier; every power step is one
  // registered multiply followed by a floor shift back to Q.12. The row sum
  // then folds in one lane per cycle while the terms shift down toward lane 0.
  // --------------------------------------------------------------------------
  logic signed [wpst_pkg::ELEM_W-1:0]                 in_elem [wpst_pkg::LANES];
  logic signed [wpst_pkg::ELEM_W-1:0]                 elem_r  [wpst_pkg::LANES];
  logic signed [wpst_pkg::TERM_W-1:0]                 term_r  [wpst_pkg::LANES];
  logic signed [wpst_pkg::TERM_W+wpst_pkg::ELEM_W-1:0] prod    [wpst_pkg::LANES];
  logic signed [wpst_pkg::ROW_W-1:0]                  row_acc_r;

  assign in_elem[0] = in_if.elem_0;
  assign in_elem[1] = in_if.elem_1;
  assign in_elem[2] = in_if.elem_2;
  assign in_elem[3] = in_if.elem_3;
  assign in_elem[4] = in_if.elem_4;
  assign in_elem[5] = in_if.elem_5;
  assign in_elem[6] = in_if.elem_6;
  assign in_elem[7] = in_if.elem_7;

  always_comb begin
    for (int i = 0; i < wpst_pkg::LANES; i++) begin
      prod[i] = term_r[i] * elem_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < wpst_pkg::LANES; i++) begin
        elem_r[i] <= in_elem[i];
        term_r[i] <= wpst_pkg::TERM_W'(in_elem[i]);
      end
      row_acc_r <= '0;
    end else if (state_r == wpst_pkg::S_POW) begin
      for (int i = 0; i < wpst_pkg::LANES; i++) begin
        term_r[i] <= wpst_pkg::TERM_W'(prod[i] >>> wpst_pkg::FRAC_W);
      end
    end else if (state_r == wpst_pkg::S_SUM) begin
      row_acc_r <= row_acc_r + wpst_pkg::ROW_W'(term_r[0]);
      for (int i = 0; i < wpst_pkg::LANES - 1; i++) begin
        term_r[i] <= term_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_cnt_r  <= '0;
      lane_cnt_r <= '0;
    end else if (in_fire) begin
      pow_cnt_r  <= wpst_pkg::POW_CNT_W'(pow_eff - wpst_pkg::POW_W'(1));
      lane_cnt_r <= '0;
    end else if (state_r == wpst_pkg::S_POW) begin
      pow_cnt_r <= pow_cnt_r - wpst_pkg::POW_CNT_W'(1);
    end else if (state_r == wpst_pkg::S_SUM) begin
      lane_cnt_r <= lane_cnt_r + wpst_pkg::COLS_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Row-sum ring. The entry at the current position is read while the row is
  // being summed and overwritten in the update cycle; only one word is in
  // flight, so the read and the write of one entry never overlap.
  // --------------------------------------------------------------------------
  logic signed [wpst_pkg::ROW_W-1:0] ring_mem [WIN_MAX];
  logic signed [wpst_pkg::ROW_W-1:0] ring_rd_r;
  logic [ADDR_W-1:0]                 ring_pos_r;

  always_ff @(posedge clk) begin
    if (state_r == wpst_pkg::S_UPD) begin
      ring_mem[ring_pos_r] <= row_acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r != wpst_pkg::S_IDLE) begin
      ring_rd_r <= ring_mem[ring_pos_r];
    end
  end

  // --------------------------------------------------------------------------
  // Window history: running sum, ring position, fill count, stride phase and
  // window counter.
  // --------------------------------------------------------------------------
  logic signed [wpst_pkg::SUM_W-1:0] running_sum_r;
  logic [LEN_W-1:0]                  rows_filled_r;
  logic [wpst_pkg::STRIDE_W-1:0]     stride_phase_r;
  logic [wpst_pkg::IDX_W-1:0]        win_count_r;

  logic [ADDR_W-1:0]                 pos_wrap;
  logic [ADDR_W-1:0]                 pos_nxt;
  logic signed [wpst_pkg::ROW_W-1:0] sub_val;
  logic signed [wpst_pkg::SUM_W-1:0] running_sum_nxt;
  logic [LEN_W-1:0]                  rows_filled_nxt;
  logic [wpst_pkg::STRIDE_W-1:0]     stride_phase_nxt;
  logic [wpst_pkg::STRIDE_W-1:0]     phase_inc;
  logic [LEN_W-1:0]                  filled_inc;

  always_comb begin
    pos_wrap = (LEN_W'(ring_pos_r) >= len_eff) ? '0 : ring_pos_r;
    pos_nxt  = ((LEN_W'(ring_pos_r) + LEN_W'(1)) >= len_eff) ?
               '0 : ring_pos_r + ADDR_W'(1);

    // Once the window is full, the oldest row sum leaves as the new one enters.
    sub_val         = (rows_filled_r >= len_eff) ? ring_rd_r : '0;
    running_sum_nxt = running_sum_r - wpst_pkg::SUM_W'(sub_val)
                    + wpst_pkg::SUM_W'(row_acc_r);

    filled_inc = rows_filled_r + LEN_W'(1);
    phase_inc  = stride_phase_r + wpst_pkg::STRIDE_W'(1);

    if (rows_filled_r < len_eff) begin
      // Still filling the first window: it closes when the count reaches the length.
      rows_filled_nxt  = filled_inc;
      upd_emit         = (filled_inc == len_eff);
      stride_phase_nxt = upd_emit ? '0 : stride_phase_r;
    end else begin
      rows_filled_nxt  = rows_filled_r;
      upd_emit         = (phase_inc >= stride_eff);
      stride_phase_nxt = upd_emit ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      running_sum_r  <= '0;
      ring_pos_r     <= '0;
      rows_filled_r  <= '0;
      stride_phase_r <= '0;
      win_count_r    <= '0;
    end else begin
      if (in_fire) begin
        if (in_if.restart) begin
          running_sum_r  <= '0;
          ring_pos_r     <= '0;
          rows_filled_r  <= '0;
          stride_phase_r <= '0;
          win_count_r    <= '0;
        end else begin
          ring_pos_r <= pos_wrap;
        end
      end
      if (state_r == wpst_pkg::S_UPD) begin
        running_sum_r  <= running_sum_nxt;
        ring_pos_r     <= pos_nxt;
        rows_filled_r  <= rows_filled_nxt;
        stride_phase_r <= stride_phase_nxt;
      end
      if ((state_r == wpst_pkg::S_EMIT) && out_free) begin
        win_count_r <= win_count_r + wpst_pkg::IDX_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It holds a result until the sink takes it, so the next
  // input word can already be at work behind it.
  // --------------------------------------------------------------------------
  logic signed [wpst_pkg::SUM_W-1:0] out_sum_r;
  logic                              out_anom_r;
  logic [wpst_pkg::IDX_W-1:0]        out_idx_r;
  logic                              out_load;

  assign out_load = (state_r == wpst_pkg::S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r  <= running_sum_r;
      out_anom_r <= (running_sum_r > thr_r);
      out_idx_r  <= win_count_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.window_sum   = out_sum_r;
  assign out_if.anomaly      = out_anom_r;
  assign out_if.window_index = out_idx_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rows_filled_r <= len_eff)
    else $error("fill count exceeds the window length");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wpst_pkg::S_IDLE) |-> (LEN_W'(ring_pos_r) < len_eff))
    else $error("ring position outside the window while a word is in work");

  a_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    stride_phase_r < stride_eff)
    else $error("stride phase reached the stride");

  a_emit_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wpst_pkg::S_EMIT) |-> (stride_phase_r == '0))
    else $error("result pending without a closed window");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == wpst_pkg::S_EMIT))
    else $error("result appeared outside the emit step");

endmodule
